>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions of the vector unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/vec3_pkg.sv
// ----------------------------------------------------------------------------
// vec3_pkg
// Types, codes and saturation helpers shared by the vector unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vec3_pkg;

	typedef enum logic [2:0] {
		KIND_ADD   = 3'd0,
		KIND_SUB   = 3'd1,
		KIND_SCALE = 3'd2,
		KIND_CROSS = 3'd3,
		KIND_DOT   = 3'd4,
		KIND_LEN   = 3'd5,
		KIND_NORM  = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] a_x;
		logic signed [15:0] a_y;
		logic signed [15:0] a_z;
		logic signed [15:0] r_x;
		logic signed [15:0] r_y;
		logic signed [15:0] r_z;
		logic signed [31:0] r_scalar;
		logic [31:0]        sq;
	} vec3_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} vec3_qstat_t;

	localparam int QDEPTH = 4;

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd32767) r = 16'sh7fff;
		else if (v < -34'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Fixed-point three-component vector unit: add, subtract, scale, cross,
// dot, length and normalize.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock cycle while s_tready is high and
// returns one result per transaction, in order. Every transaction passes the
// same pipeline: two front stages that form all products, one queue slot,
// one square-root stage per root bit (16 + FRAC_BITS), a rounding stage, one
// divider stage per quotient bit (FRAC_BITS + 2) and the output register. A
// four-entry queue between the front and the back lets each half stall on
// its own.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vector3_alu import vec3_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
	input  wire logic [111:0] s_tdata,
	// kind
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// r_x, r_y, r_z, r_scalar
	output logic [79:0]       m_tdata,
	// zero_length
	output logic [0:0]        m_tuser
);

	logic signed [15:0] in_a [3];
	logic signed [15:0] in_b [3];
	logic               push;
	logic               pop;
	vec3_entry_t        push_entry;
	vec3_entry_t        pop_entry;
	vec3_qstat_t        qstat;
	logic [15:0]        out_x;
	logic [15:0]        out_y;
	logic [15:0]        out_z;
	logic [31:0]        out_scalar;
	logic               out_zl;

	assign in_a[0] = s_tdata[15:0];
	assign in_a[1] = s_tdata[31:16];
	assign in_a[2] = s_tdata[47:32];
	assign in_b[0] = s_tdata[63:48];
	assign in_b[1] = s_tdata[79:64];
	assign in_b[2] = s_tdata[95:80];

	vec3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_a       (in_a),
		.in_b       (in_b),
		.in_k       (s_tdata[111:96]),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	vec3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	vec3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_scalar (out_scalar),
		.out_zl     (out_zl)
	);

	assign m_tdata = {out_scalar, out_z, out_y, out_x};
	assign m_tuser = out_zl;

	`VEC_ASSERT_IMP(a_zero_len_clean, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0, "zero-length result carries nonzero data")
	`VEC_ASSERT_IMP(a_stall_on_full, clk, arst_n, !s_tready, qstat.full, "input stalled while queue has room")
	`VEC_ASSERT_NXT(a_full_not_drained, clk, arst_n, qstat.full, !qstat.empty, "queue emptied within one cycle of full")

endmodule

`default_nettype wire

>>> rtl/core/vec3_front.sv
// ----------------------------------------------------------------------------
// vec3_front
// Accepts transactions, forms all products and finishes the simple kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vec3_front import vec3_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         in_kind,
	input  wire logic signed [15:0] in_a [3],
	input  wire logic signed [15:0] in_b [3],
	input  wire logic signed [15:0] in_k,
	input  wire vec3_qstat_t        qstat,
	output logic                    push,
	output vec3_entry_t             push_entry
);

	localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

	logic               adv;
	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic signed [15:0] a_s1 [3];
	logic signed [15:0] b_s1 [3];
	logic signed [31:0] pa_s1 [3];
	logic signed [31:0] pd_s1 [3];
	logic signed [31:0] pk_s1 [3];
	logic signed [31:0] pc_s1 [6];
	logic               valid_s2;
	vec3_entry_t        entry_s2;
	vec3_entry_t        entry_d;

	function automatic logic signed [15:0] rnd(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + HALF) >>> FRAC_BITS;
		return sat16(t);
	endfunction

	assign adv      = !valid_s2 || !qstat.full;
	assign in_ready = adv;
	assign push     = valid_s2 && !qstat.full;
	assign push_entry = entry_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= in_kind;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= in_a[i];
				b_s1[i]  <= in_b[i];
				pa_s1[i] <= 32'(in_a[i]) * 32'(in_a[i]);
				pd_s1[i] <= 32'(in_a[i]) * 32'(in_b[i]);
				pk_s1[i] <= 32'(in_a[i]) * 32'(in_k);
			end
			pc_s1[0] <= 32'(in_a[1]) * 32'(in_b[2]);
			pc_s1[1] <= 32'(in_a[2]) * 32'(in_b[1]);
			pc_s1[2] <= 32'(in_a[2]) * 32'(in_b[0]);
			pc_s1[3] <= 32'(in_a[0]) * 32'(in_b[2]);
			pc_s1[4] <= 32'(in_a[0]) * 32'(in_b[1]);
			pc_s1[5] <= 32'(in_a[1]) * 32'(in_b[0]);
			entry_s2 <= entry_d;
		end
	end

	always_comb begin
		entry_d          = '0;
		entry_d.kind     = kind_s1;
		entry_d.a_x      = a_s1[0];
		entry_d.a_y      = a_s1[1];
		entry_d.a_z      = a_s1[2];
		entry_d.sq       = $unsigned(pa_s1[0]) + $unsigned(pa_s1[1]) + $unsigned(pa_s1[2]);
		unique case (kind_t'(kind_s1))
			KIND_ADD: begin
				entry_d.r_x = sat16(34'(a_s1[0]) + 34'(b_s1[0]));
				entry_d.r_y = sat16(34'(a_s1[1]) + 34'(b_s1[1]));
				entry_d.r_z = sat16(34'(a_s1[2]) + 34'(b_s1[2]));
			end
			KIND_SUB: begin
				entry_d.r_x = sat16(34'(a_s1[0]) - 34'(b_s1[0]));
				entry_d.r_y = sat16(34'(a_s1[1]) - 34'(b_s1[1]));
				entry_d.r_z = sat16(34'(a_s1[2]) - 34'(b_s1[2]));
			end
			KIND_SCALE: begin
				entry_d.r_x = rnd(34'(pk_s1[0]));
				entry_d.r_y = rnd(34'(pk_s1[1]));
				entry_d.r_z = rnd(34'(pk_s1[2]));
			end
			KIND_CROSS: begin
				entry_d.r_x = rnd(34'(pc_s1[0]) - 34'(pc_s1[1]));
				entry_d.r_y = rnd(34'(pc_s1[2]) - 34'(pc_s1[3]));
				entry_d.r_z = rnd(34'(pc_s1[4]) - 34'(pc_s1[5]));
			end
			KIND_DOT: begin
				entry_d.r_scalar = sat32(34'(pd_s1[0]) + 34'(pd_s1[1]) + 34'(pd_s1[2]));
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/vec3_fifo.sv
// ----------------------------------------------------------------------------
// vec3_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vec3_fifo import vec3_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire vec3_entry_t push_entry,
	input  wire logic        pop,
	output vec3_entry_t      pop_entry,
	output vec3_qstat_t      qstat
);

	localparam int PW = $clog2(QDEPTH);

	vec3_entry_t   mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign qstat.full  = (count_q == (PW+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

>>> rtl/core/vec3_back.sv
// ----------------------------------------------------------------------------
// vec3_back
// Pipelined square root and divider for length and normalize, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vec3_back import vec3_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vec3_qstat_t qstat,
	input  wire vec3_entry_t pop_entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      out_x,
	output logic [15:0]      out_y,
	output logic [15:0]      out_z,
	output logic [31:0]      out_scalar,
	output logic             out_zl
);

	localparam int F2 = 2 * FRAC_BITS;
	localparam int RW = 16 + FRAC_BITS;
	localparam int XW = 2 * RW;
	localparam int QB = FRAC_BITS + 2;
	localparam int DW = 2 * FRAC_BITS + 18;

	logic adv;

	logic          v_s    [RW+1];
	vec3_entry_t   e_s    [RW+1];
	logic [XW-1:0] x_s    [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [RW:0]   rem_s  [RW+1];

	logic          v_ln_s;
	vec3_entry_t   e_ln_s;
	logic [RW-1:0] len_ln_s;
	logic [RW-1:0] len_d;

	logic          v_dv_s   [QB+1];
	vec3_entry_t   e_dv_s   [QB+1];
	logic [RW-1:0] len_dv_s [QB+1];
	logic [DW-1:0] r_dv_s   [QB+1][3];
	logic [QB-1:0] q_dv_s   [QB+1][3];

	logic signed [15:0] a_ln [3];
	logic signed [15:0] a_o  [3];
	logic signed [15:0] rv_d [3];
	logic [31:0]        rsc_d;
	logic               zl_d;

	logic               out_valid_q;
	logic [15:0]        rx_q;
	logic [15:0]        ry_q;
	logic [15:0]        rz_q;
	logic [31:0]        rsc_q;
	logic               zl_q;

	assign adv    = !out_valid_q || out_ready;
	assign pop    = adv && !qstat.empty;
	assign v_s[0]    = !qstat.empty;
	assign e_s[0]    = pop_entry;
	assign x_s[0]    = {pop_entry.sq, {F2{1'b0}}};
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+2:0] rem_sh;
		logic [RW+2:0] trial;
		logic          ge;

		always_comb begin
			rem_sh = {rem_s[k], x_s[k][XW-1 -: 2]};
			trial  = (RW+3)'({root_s[k], 2'b01});
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (adv) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				e_s[k+1]    <= e_s[k];
				x_s[k+1]    <= {x_s[k][XW-3:0], 2'b00};
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				rem_s[k+1]  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
			end
		end
	end

	assign len_d = root_s[RW] + RW'(rem_s[RW] > {1'b0, root_s[RW]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_ln_s <= 1'b0;
		else if (adv) v_ln_s <= v_s[RW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_ln_s   <= e_s[RW];
			len_ln_s <= len_d;
		end
	end

	assign a_ln[0] = e_ln_s.a_x;
	assign a_ln[1] = e_ln_s.a_y;
	assign a_ln[2] = e_ln_s.a_z;
	assign v_dv_s[0]   = v_ln_s;
	assign e_dv_s[0]   = e_ln_s;
	assign len_dv_s[0] = len_ln_s;

	for (genvar l = 0; l < 3; l++) begin : g_num
		logic [15:0] mag;

		always_comb begin
			mag = a_ln[l][15] ? 16'(-a_ln[l]) : a_ln[l];
		end

		assign r_dv_s[0][l] = DW'({mag, {F2{1'b0}}}) + DW'(len_ln_s >> 1);
		assign q_dv_s[0][l] = '0;
	end

	for (genvar m = 0; m < QB; m++) begin : g_div
		logic [DW-1:0] dsh;

		assign dsh = DW'(len_dv_s[m]) << (QB - 1 - m);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv_s[m+1] <= 1'b0;
			else if (adv) v_dv_s[m+1] <= v_dv_s[m];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				e_dv_s[m+1]   <= e_dv_s[m];
				len_dv_s[m+1] <= len_dv_s[m];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic ge;

			assign ge = (r_dv_s[m][l] >= dsh);

			always_ff @(posedge clk) begin
				if (adv) begin
					r_dv_s[m+1][l] <= ge ? r_dv_s[m][l] - dsh : r_dv_s[m][l];
					q_dv_s[m+1][l] <= {q_dv_s[m][l][QB-2:0], ge};
				end
			end
		end
	end

	assign a_o[0] = e_dv_s[QB].a_x;
	assign a_o[1] = e_dv_s[QB].a_y;
	assign a_o[2] = e_dv_s[QB].a_z;

	always_comb begin
		logic signed [33:0] qv;
		rv_d[0] = e_dv_s[QB].r_x;
		rv_d[1] = e_dv_s[QB].r_y;
		rv_d[2] = e_dv_s[QB].r_z;
		rsc_d   = e_dv_s[QB].r_scalar;
		zl_d    = 1'b0;
		qv      = '0;
		case (kind_t'(e_dv_s[QB].kind))
			KIND_LEN: begin
				rsc_d = 32'(len_dv_s[QB]);
			end
			KIND_NORM: begin
				if (len_dv_s[QB] == '0) begin
					zl_d = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						qv = 34'(q_dv_s[QB][i]);
						if (a_o[i][15]) qv = -qv;
						rv_d[i] = sat16(qv);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_dv_s[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_q  <= rv_d[0];
			ry_q  <= rv_d[1];
			rz_q  <= rv_d[2];
			rsc_q <= rsc_d;
			zl_q  <= zl_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = rx_q;
	assign out_y      = ry_q;
	assign out_z      = rz_q;
	assign out_scalar = rsc_q;
	assign out_zl     = zl_q;

endmodule

`default_nettype wire
